/* rtl/sas_pkg.sv */
// ----------------------------------------------------------------------------
// sas_pkg
// types, sizes and codes shared by the sorted array store
// ----------------------------------------------------------------------------
package sas_pkg;

   localparam int DEPTH      = 64;
   localparam int WORD_BITS  = 32;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   localparam int OP_BITS     = 2;
   localparam int KEY_BITS    = 32;
   localparam int POS_BITS    = 6;
   localparam int STATUS_BITS = 2;
   localparam int CAP_BITS    = 7;
   localparam int RSP_CNT_BITS = 7;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(64);

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
      addr_type rd_addr;
   } mem_cmd_type;

endpackage

/* rtl/sas_req_if.sv */
// ----------------------------------------------------------------------------
// sas_req_if
// request channel: operation, key and position
// ----------------------------------------------------------------------------
interface sas_req_if;
   logic                         valid;
   logic                         ready;
   logic [sas_pkg::OP_BITS-1:0]  op;
   logic [sas_pkg::KEY_BITS-1:0] key_value;
   logic [sas_pkg::POS_BITS-1:0] position;

   modport source (output valid, op, key_value, position, input ready);
   modport sink   (input valid, op, key_value, position, output ready);
endinterface

/* rtl/sas_rsp_if.sv */
// ----------------------------------------------------------------------------
// sas_rsp_if
// response channel: read value, status and entry count
// ----------------------------------------------------------------------------
interface sas_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sas_pkg::KEY_BITS-1:0]     read_value;
   logic [sas_pkg::STATUS_BITS-1:0]  status;
   logic [sas_pkg::RSP_CNT_BITS-1:0] count;

   modport source (output valid, read_value, status, count, input ready);
   modport sink   (input valid, read_value, status, count, output ready);
endinterface

/* rtl/sas_csr_if.sv */
// ----------------------------------------------------------------------------
// sas_csr_if
// capacity register write channel
// ----------------------------------------------------------------------------
interface sas_csr_if;
   logic                         valid;
   logic                         ready;
   logic [sas_pkg::CAP_BITS-1:0] capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

/* rtl/sas_ram.sv */
// ----------------------------------------------------------------------------
// sas_ram
// entry storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sas_ram (
   input  logic                 clock,
   input  sas_pkg::mem_cmd_type mem_cmd,
   output sas_pkg::word_type    rd_data
);

   sas_pkg::word_type mem [sas_pkg::DEPTH];
   sas_pkg::word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
      rd_data_ff <= mem[mem_cmd.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sas_seq.sv */
// ----------------------------------------------------------------------------
// sas_seq
// sequencer: search, shift and read through the shared compare and memory port
// ----------------------------------------------------------------------------
module sas_seq (
   input  logic                 clock,
   input  logic                 reset,
   sas_req_if.sink              req,
   sas_rsp_if.source            rsp,
   input  sas_pkg::count_type   limit,
   output sas_pkg::mem_cmd_type mem_cmd,
   input  sas_pkg::word_type    rd_data
);

   typedef enum logic [2:0] {
      IDLE,
      INS_RD,
      INS_CMP,
      LKP_WAIT,
      REM_RD,
      REM_WR,
      FINISH
   } state_type;

   state_type                             state_ff, state_in;
   sas_pkg::count_type                    k_ff, k_in;
   sas_pkg::count_type                    count_ff, count_in;
   sas_pkg::word_type                     key_ff, key_in;
   sas_pkg::word_type                     rd_ff, rd_in;
   logic [sas_pkg::STATUS_BITS-1:0]       status_ff, status_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [sas_pkg::KEY_BITS-1:0]          read_value_ff, read_value_in;
   logic [sas_pkg::STATUS_BITS-1:0]       rsp_status_ff, rsp_status_in;
   logic [sas_pkg::RSP_CNT_BITS-1:0]      rsp_count_ff, rsp_count_in;
   sas_pkg::count_type                    km1;
   sas_pkg::count_type                    kp1;
   sas_pkg::count_type                    req_pos;

   assign km1     = k_ff - sas_pkg::COUNT_BITS'(1);
   assign kp1     = k_ff + sas_pkg::COUNT_BITS'(1);
   assign req_pos = sas_pkg::COUNT_BITS'(req.position);

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      rd_in         = rd_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      read_value_in = read_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      mem_cmd.wr_en   = 1'b0;
      mem_cmd.wr_addr = k_ff[sas_pkg::ADDR_BITS-1:0];
      mem_cmd.wr_data = key_ff;
      mem_cmd.rd_addr = km1[sas_pkg::ADDR_BITS-1:0];

      unique case (state_ff)
         IDLE: begin
            if (req.valid) begin
               key_in    = sas_pkg::WORD_BITS'(req.key_value);
               rd_in     = '0;
               status_in = sas_pkg::STATUS_OK;
               unique case (req.op)
                  sas_pkg::OP_INSERT: begin
                     if (count_ff >= limit) begin
                        status_in = sas_pkg::STATUS_FULL;
                        state_in  = FINISH;
                     end else begin
                        k_in     = count_ff;
                        state_in = INS_RD;
                     end
                  end
                  sas_pkg::OP_LOOKUP: begin
                     if (req_pos >= count_ff) begin
                        status_in = sas_pkg::STATUS_RANGE;
                        state_in  = FINISH;
                     end else begin
                        mem_cmd.rd_addr = sas_pkg::ADDR_BITS'(req.position);
                        state_in        = LKP_WAIT;
                     end
                  end
                  sas_pkg::OP_REMOVE: begin
                     if (req_pos >= count_ff) begin
                        status_in = sas_pkg::STATUS_RANGE;
                        state_in  = FINISH;
                     end else begin
                        k_in     = req_pos;
                        state_in = REM_RD;
                     end
                  end
                  default: begin
                     state_in = FINISH;
                  end
               endcase
            end
         end
         INS_RD: begin
            if (k_ff == '0) begin
               mem_cmd.wr_en = 1'b1;
               count_in      = count_ff + sas_pkg::COUNT_BITS'(1);
               state_in      = FINISH;
            end else begin
               state_in = INS_CMP;
            end
         end
         INS_CMP: begin
            mem_cmd.wr_en = 1'b1;
            if (rd_data < key_ff) begin
               count_in = count_ff + sas_pkg::COUNT_BITS'(1);
               state_in = FINISH;
            end else begin
               mem_cmd.wr_data = rd_data;
               k_in            = km1;
               state_in        = INS_RD;
            end
         end
         LKP_WAIT: begin
            rd_in    = rd_data;
            state_in = FINISH;
         end
         REM_RD: begin
            if (kp1 >= count_ff) begin
               count_in = count_ff - sas_pkg::COUNT_BITS'(1);
               state_in = FINISH;
            end else begin
               mem_cmd.rd_addr = kp1[sas_pkg::ADDR_BITS-1:0];
               state_in        = REM_WR;
            end
         end
         REM_WR: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_data = rd_data;
            k_in            = kp1;
            state_in        = REM_RD;
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               read_value_in = sas_pkg::KEY_BITS'(rd_ff);
               rsp_status_in = status_ff;
               rsp_count_in  = sas_pkg::RSP_CNT_BITS'(count_ff);
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      key_ff        <= key_in;
      rd_ff         <= rd_in;
      status_ff     <= status_in;
      read_value_ff <= read_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req.ready      = (state_ff == IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.read_value = read_value_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.count      = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sas_pkg::COUNT_BITS'(sas_pkg::DEPTH))
      else $error("entry count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(count_ff) |->
         count_ff == $past(count_ff) + sas_pkg::COUNT_BITS'(1) ||
         count_ff == $past(count_ff) - sas_pkg::COUNT_BITS'(1))
      else $error("entry count moved by more than one");

   a_ins_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == INS_RD || state_ff == INS_CMP |-> k_ff <= count_ff)
      else $error("insert index beyond count");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |->
         state_ff == INS_RD || state_ff == INS_CMP || state_ff == REM_WR)
      else $error("memory write outside a shift step");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == FINISH && (!rsp_valid_ff || rsp.ready) |=> rsp.valid)
      else $error("finished item not presented");

endmodule

/* rtl/sorted_array_store.sv */
// ----------------------------------------------------------------------------
// sorted_array_store
// ordered table of words with insert, lookup by index and remove by index
// ----------------------------------------------------------------------------
// req_ch carries one item: op (insert, lookup, remove), key_value, position.
// rsp_ch returns one item per request: read_value (lookup only, else zero),
// status (ok, index out of range, store full) and the count afterwards.
// csr_ch writes the capacity register; it is always ready and takes effect
// on the next request. Writes are expected only while the block is idle.
// One request is worked at a time; req_ch is ready only when the sequencer
// is idle. The entry memory has one write port and one registered read
// port, so entries are moved one at a time through the read port, and the
// one comparator decides where an inserted key stops. A lookup reads one
// entry; an insert shifts the entries not below the key up one slot; a
// remove shifts the entries above the removed index down one slot.
// req_ch is ready again in the cycle rsp_ch valid rises, so the next request
// is accepted while a finished response still waits; a stalled rsp_ch holds
// its item and a second result waits in the sequencer, which blocks req_ch.
// Reset empties the store and sets capacity to 64; memory is not cleared.
// ----------------------------------------------------------------------------
module sorted_array_store (
   input logic       clock,
   input logic       reset,
   sas_req_if.sink   req_ch,
   sas_rsp_if.source rsp_ch,
   sas_csr_if.sink   csr_ch
);

   logic [sas_pkg::CAP_BITS-1:0] cap_ff;
   sas_pkg::count_type           cap_count;
   sas_pkg::count_type           limit;
   sas_pkg::mem_cmd_type         mem_cmd;
   sas_pkg::word_type            rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= sas_pkg::CAP_RESET;
      end else if (csr_ch.valid) begin
         cap_ff <= csr_ch.capacity;
      end
   end

   assign csr_ch.ready = 1'b1;
   assign cap_count    = sas_pkg::COUNT_BITS'(cap_ff);
   assign limit        = (cap_count > sas_pkg::COUNT_BITS'(sas_pkg::DEPTH))
                         ? sas_pkg::COUNT_BITS'(sas_pkg::DEPTH) : cap_count;

   sas_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .limit   (limit),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   sas_ram u_ram (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

endmodule

/* verif/sas_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_checker
// Watches the request, response and capacity channels of the sorted array
// store. Every accepted request is applied to a shadow table kept in
// ascending order, and the outcome is queued. Every accepted response is
// compared field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module sas_checker
   import sas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sas_req_if          req_ch,
   sas_rsp_if          rsp_ch,
   sas_csr_if          csr_ch,
   output int unsigned mismatches,
   output int unsigned pending,
   output int unsigned level
);

   typedef struct packed {
      logic [KEY_BITS-1:0]     read_value;
      logic [STATUS_BITS-1:0]  status;
      logic [RSP_CNT_BITS-1:0] count;
   } outcome_t;

   word_type            entries [DEPTH];
   int unsigned         fill = 0;
   logic [CAP_BITS-1:0] capacity = CAP_RESET;
   outcome_t            awaited [$];
   int unsigned         errors = 0;

   function automatic outcome_t apply_request(input logic [OP_BITS-1:0]  op,
                                              input word_type            key,
                                              input logic [POS_BITS-1:0] pos);
      outcome_t    result;
      int unsigned ceiling;
      int unsigned slot;
      result = '0;
      ceiling = (capacity > DEPTH) ? DEPTH : capacity;
      case (op)
         OP_INSERT: begin
            if (fill >= ceiling) begin
               result.status = STATUS_FULL;
            end else begin
               slot = 0;
               while (slot < fill && entries[slot] < key) slot++;
               for (int k = fill; k > slot; k--) entries[k] = entries[k-1];
               entries[slot] = key;
               fill++;
            end
         end
         OP_LOOKUP: begin
            if (pos < fill) result.read_value = entries[pos];
            else result.status = STATUS_RANGE;
         end
         OP_REMOVE: begin
            if (pos >= fill) begin
               result.status = STATUS_RANGE;
            end else begin
               for (int k = pos; k + 1 < fill; k++) entries[k] = entries[k+1];
               fill--;
            end
         end
         default: begin
         end
      endcase
      result.count = RSP_CNT_BITS'(fill);
      return result;
   endfunction

   always @(posedge clock) begin
      outcome_t seen;
      outcome_t wanted;
      if (reset) begin
         fill = 0;
         capacity = CAP_RESET;
         awaited.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) capacity = csr_ch.capacity;
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.read_value = rsp_ch.read_value;
            seen.status = rsp_ch.status;
            seen.count = rsp_ch.count;
            if (awaited.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response with nothing pending: value %h status %0d count %0d",
                           $realtime, seen.read_value, seen.status, seen.count);
            end else begin
               wanted = awaited.pop_front();
               if (seen.read_value !== wanted.read_value || seen.status !== wanted.status
                   || seen.count !== wanted.count) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: expected %h st %0d cnt %0d, got %h st %0d cnt %0d",
                              $realtime, wanted.read_value, wanted.status, wanted.count,
                              seen.read_value, seen.status, seen.count);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            awaited.push_back(apply_request(req_ch.op, word_type'(req_ch.key_value),
                                            req_ch.position));
      end
      mismatches = errors;
      pending = awaited.size();
      level = fill;
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sorted array store with a short directed sequence (empty,
// full, equal keys, index edges, capacity zero, saturated and lowered
// capacity, unused op code) and then random phases that fill and drain the
// table under several capacities. Both channels stall at random; the
// checker predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import sas_pkg::*;

   localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 140;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 160;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   bit                  steady = 1'b0;
   logic [CAP_BITS-1:0] cap_now = CAP_RESET;
   int unsigned         mismatches;
   int unsigned         pending;
   int unsigned         level;
   int unsigned         stall_cycles = 0;

   sas_req_if req_bus ();
   sas_rsp_if rsp_bus ();
   sas_csr_if csr_bus ();

   sorted_array_store dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   sas_checker sorted_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_bus),
      .rsp_ch     (rsp_bus),
      .csr_ch     (csr_bus),
      .mismatches (mismatches),
      .pending    (pending),
      .level      (level)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= steady || ($urandom_range(99) >= 24);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic bit take_gap();
      return !steady && ($urandom_range(99) < 24);
   endfunction

   task automatic push_request(input logic [OP_BITS-1:0]  op,
                               input logic [KEY_BITS-1:0] key,
                               input logic [POS_BITS-1:0] pos);
      if (take_gap()) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
         while (take_gap()) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.key_value <= key;
      req_bus.position <= pos;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.capacity <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      cap_now = value;
   endtask

   initial begin
      bit                  filling;
      int unsigned         ceiling;
      int unsigned         roll;
      logic [OP_BITS-1:0]  op;
      logic [KEY_BITS-1:0] key;
      logic [POS_BITS-1:0] pos;
      logic [CAP_BITS-1:0] phase_caps [PHASES];

      req_bus.valid = 1'b0;
      req_bus.op = OP_INSERT;
      req_bus.key_value = '0;
      req_bus.position = '0;
      csr_bus.valid = 1'b0;
      csr_bus.capacity = CAP_RESET;
      phase_caps = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd5, 7'd65,
                     CAP_BITS'($urandom_range(3, 126)), 7'd64};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table, index edges, equal keys
      push_request(OP_LOOKUP, 32'h0, 6'd0);
      push_request(OP_REMOVE, 32'h0, 6'd63);
      push_request(OP_SPARE, 32'hFFFF_FFFF, 6'd63);
      push_request(OP_INSERT, 32'hFFFF_FFFF, 6'd0);
      push_request(OP_INSERT, 32'h0, 6'd0);
      push_request(OP_INSERT, 32'h5, 6'd0);
      push_request(OP_INSERT, 32'h5, 6'd0);
      push_request(OP_INSERT, 32'h7, 6'd0);
      push_request(OP_LOOKUP, 32'h0, 6'd0);
      push_request(OP_LOOKUP, 32'h0, 6'd1);
      push_request(OP_LOOKUP, 32'h0, 6'd4);
      push_request(OP_LOOKUP, 32'h0, 6'd5);
      push_request(OP_REMOVE, 32'h0, 6'd1);
      push_request(OP_REMOVE, 32'h0, 6'd3);
      push_request(OP_INSERT, 32'h8000_0000, 6'd0);

      // capacity zero
      settle();
      write_capacity(7'd0);
      push_request(OP_INSERT, 32'h1, 6'd0);
      push_request(OP_LOOKUP, 32'h0, 6'd0);

      // capacity lowered below the count
      settle();
      write_capacity(7'd2);
      push_request(OP_INSERT, 32'h3, 6'd0);
      push_request(OP_REMOVE, 32'h0, 6'd0);
      push_request(OP_REMOVE, 32'h0, 6'd0);
      push_request(OP_REMOVE, 32'h0, 6'd0);
      push_request(OP_INSERT, 32'h3, 6'd0);
      push_request(OP_INSERT, 32'h9, 6'd0);

      // capacity above the depth
      settle();
      write_capacity(7'd127);
      push_request(OP_INSERT, 32'h2A, 6'd0);
      push_request(OP_LOOKUP, 32'h0, 6'd63);

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         write_capacity(phase_caps[ph]);
         steady = (ph == 2);
         filling = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            ceiling = (cap_now > DEPTH) ? DEPTH : cap_now;
            if (level == 0) filling = 1'b1;
            else if (level >= ceiling) filling = 1'b0;
            else if ($urandom_range(99) < 1) filling = !filling;
            roll = $urandom_range(99);
            if (roll < 3) op = OP_SPARE;
            else if (roll < 28) op = OP_LOOKUP;
            else if (roll < (filling ? 40 : 80)) op = OP_REMOVE;
            else op = OP_INSERT;
            case ($urandom_range(9))
               0: key = '0;
               1: key = '1;
               2, 3: key = KEY_BITS'($urandom_range(7));
               default: key = $urandom;
            endcase
            if (level > 0 && $urandom_range(99) < 85) pos = POS_BITS'($urandom_range(level - 1));
            else pos = POS_BITS'($urandom);
            push_request(op, key, pos);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
